// File: src/rie_pkg.sv
// Shared types, opcodes and constants for the integer execute unit.
package rie_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RIDX = 5;
  localparam int unsigned OPW  = 6;
  localparam int unsigned QDEPTH = 2;

  localparam logic [XLEN-1:0] RESET_PC_DEFAULT = 32'hE000_0000;

  // Opcodes
  localparam logic [OPW-1:0] OP_ADD      = 6'd0;
  localparam logic [OPW-1:0] OP_ADDI     = 6'd1;
  localparam logic [OPW-1:0] OP_SUB      = 6'd2;
  localparam logic [OPW-1:0] OP_SUBI     = 6'd3;
  localparam logic [OPW-1:0] OP_MUL      = 6'd4;
  localparam logic [OPW-1:0] OP_MULI     = 6'd5;
  localparam logic [OPW-1:0] OP_MULU     = 6'd6;
  localparam logic [OPW-1:0] OP_MULU_IMM = 6'd7;
  localparam logic [OPW-1:0] OP_DIV      = 6'd8;
  localparam logic [OPW-1:0] OP_DIVI     = 6'd9;
  localparam logic [OPW-1:0] OP_DIVU     = 6'd10;
  localparam logic [OPW-1:0] OP_DIVU_IMM = 6'd11;
  localparam logic [OPW-1:0] OP_REM      = 6'd12;
  localparam logic [OPW-1:0] OP_REMI     = 6'd13;
  localparam logic [OPW-1:0] OP_REMU     = 6'd14;
  localparam logic [OPW-1:0] OP_REMU_IMM = 6'd15;
  localparam logic [OPW-1:0] OP_AND      = 6'd16;
  localparam logic [OPW-1:0] OP_ANDI     = 6'd17;
  localparam logic [OPW-1:0] OP_OR       = 6'd18;
  localparam logic [OPW-1:0] OP_ORI      = 6'd19;
  localparam logic [OPW-1:0] OP_XOR      = 6'd20;
  localparam logic [OPW-1:0] OP_XORI     = 6'd21;
  localparam logic [OPW-1:0] OP_XNOR     = 6'd22;
  localparam logic [OPW-1:0] OP_XNOR_IMM = 6'd23;
  localparam logic [OPW-1:0] OP_SLL      = 6'd24;
  localparam logic [OPW-1:0] OP_SLLI     = 6'd25;
  localparam logic [OPW-1:0] OP_SLR      = 6'd26;
  localparam logic [OPW-1:0] OP_SLRI     = 6'd27;
  localparam logic [OPW-1:0] OP_SAR      = 6'd28;
  localparam logic [OPW-1:0] OP_SARI     = 6'd29;
  localparam logic [OPW-1:0] OP_LDHI     = 6'd30;
  localparam logic [OPW-1:0] OP_BEQ      = 6'd31;
  localparam logic [OPW-1:0] OP_BNE      = 6'd32;
  localparam logic [OPW-1:0] OP_BLE      = 6'd33;
  localparam logic [OPW-1:0] OP_BLEU     = 6'd34;
  localparam logic [OPW-1:0] OP_BLT      = 6'd35;
  localparam logic [OPW-1:0] OP_BLTU     = 6'd36;
  localparam logic [OPW-1:0] OP_BGE      = 6'd37;
  localparam logic [OPW-1:0] OP_BGEU     = 6'd38;
  localparam logic [OPW-1:0] OP_BGT      = 6'd39;
  localparam logic [OPW-1:0] OP_BGTU     = 6'd40;
  localparam logic [OPW-1:0] OP_J        = 6'd41;
  localparam logic [OPW-1:0] OP_JR       = 6'd42;
  localparam logic [OPW-1:0] OP_JAL      = 6'd43;
  localparam logic [OPW-1:0] OP_JALR     = 6'd44;
  localparam logic [OPW-1:0] OP_TRAP     = 6'd45;

  localparam logic [RIDX-1:0] LINK_REG = 5'd31;

  typedef enum logic [1:0] {
    EXC_NONE      = 2'd0,
    EXC_DIVZERO   = 2'd1,
    EXC_USER_TRAP = 2'd2,
    EXC_ILLEGAL   = 2'd3
  } exc_e;

  // Functional class chosen by the front end
  typedef enum logic [2:0] {
    CL_ALU,
    CL_MUL,
    CL_DIV,
    CL_BRANCH,
    CL_JUMP,
    CL_EXC
  } class_e;

  // Operand-B source
  typedef enum logic [1:0] {
    BS_REG,
    BS_SEXT,
    BS_ZEXT
  } bsrc_e;

  // Decoded request handed from front to back
  typedef struct packed {
    logic [OPW-1:0]  op;
    class_e          cls;
    bsrc_e           bsrc;
    logic [RIDX-1:0] src_a;
    logic [RIDX-1:0] src_b;
    logic [RIDX-1:0] dst;
    logic            wr;
    logic [15:0]     imm16;
    logic [25:0]     jump_offset;
    logic            div_signed;
    logic            div_rem;
    exc_e            exc;
  } dec_t;

  // Result handed from back to output stage
  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            write_enable;
    logic [RIDX-1:0] write_reg;
    logic [XLEN-1:0] write_value;
    exc_e            exception_code;
  } res_t;

endpackage

// File: src/rie_front.sv
// Front end: accepts requests, decodes and classifies them into a short queue.
module rie_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [5:0]     op_i,
  input  logic [4:0]     src_a_i,
  input  logic [4:0]     src_b_i,
  input  logic [4:0]     dest_r_i,
  input  logic [15:0]    imm16_i,
  input  logic [25:0]    jump_offset_i,
  output logic           dq_valid_o,
  input  logic           dq_ready_i,
  output rie_pkg::dec_t  dq_data_o
);

  rie_pkg::dec_t dec;
  rie_pkg::dec_t mem_q [rie_pkg::QDEPTH];
  logic          wp_q, wp_d, rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  // Decode one request
  always_comb begin
    dec             = '0;
    dec.op          = op_i;
    dec.src_a       = src_a_i;
    dec.src_b       = src_b_i;
    dec.imm16       = imm16_i;
    dec.jump_offset = jump_offset_i;
    dec.cls         = rie_pkg::CL_ALU;
    dec.bsrc        = rie_pkg::BS_REG;
    dec.dst         = dest_r_i;
    dec.wr          = 1'b1;
    dec.exc         = rie_pkg::EXC_NONE;
    if (op_i <= rie_pkg::OP_LDHI) begin
      // odd ops below LDHI are immediate forms, LDHI too
      if (op_i[0] || op_i == rie_pkg::OP_LDHI) begin
        dec.dst = src_b_i;
        dec.bsrc = rie_pkg::BS_ZEXT;
        if (op_i == rie_pkg::OP_ADDI || op_i == rie_pkg::OP_SUBI ||
            op_i == rie_pkg::OP_MULI || op_i == rie_pkg::OP_DIVI ||
            op_i == rie_pkg::OP_REMI) begin
          dec.bsrc = rie_pkg::BS_SEXT;
        end
      end
      if (op_i >= rie_pkg::OP_MUL && op_i <= rie_pkg::OP_MULU_IMM) begin
        dec.cls = rie_pkg::CL_MUL;
      end
      if (op_i >= rie_pkg::OP_DIV && op_i <= rie_pkg::OP_REMU_IMM) begin
        dec.cls        = rie_pkg::CL_DIV;
        dec.div_signed = ~op_i[1];
        dec.div_rem    = op_i[2];
      end
    end else if (op_i <= rie_pkg::OP_BGTU) begin
      dec.cls = rie_pkg::CL_BRANCH;
      dec.wr  = 1'b0;
    end else if (op_i <= rie_pkg::OP_JALR) begin
      dec.cls = rie_pkg::CL_JUMP;
      dec.wr  = (op_i == rie_pkg::OP_JAL || op_i == rie_pkg::OP_JALR);
      dec.dst = rie_pkg::LINK_REG;
    end else begin
      dec.cls = rie_pkg::CL_EXC;
      dec.wr  = 1'b0;
      dec.exc = (op_i == rie_pkg::OP_TRAP) ? rie_pkg::EXC_USER_TRAP
                                           : rie_pkg::EXC_ILLEGAL;
    end
  end

  assign in_ready_o = (cnt_q != 2'(rie_pkg::QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign dq_valid_o = (cnt_q != 2'd0);
  assign pop        = dq_valid_o && dq_ready_i;
  assign dq_data_o  = mem_q[rp_q];

  // Advance queue pointers
  always_comb begin
    wp_d  = wp_q + 1'(push);
    rp_d  = rp_q + 1'(pop);
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= dec;
    end
  end

endmodule

// File: src/rie_div.sv
// Iterative radix-2 divider, one quotient bit per cycle.
module rie_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  logic        signed_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic        nq_q, nq_d, nr_q, nr_d;
  logic [32:0] trial;
  logic [31:0] rsh;

  assign rsh   = {r_q[30:0], q_q[31]};
  assign trial = {1'b0, rsh} - {1'b0, d_q};

  // Iterate restoring division
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    nq_d   = nq_q;
    nr_d   = nr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      nr_d   = signed_i && dividend_i[31];
      nq_d   = signed_i && (dividend_i[31] ^ divisor_i[31]);
      q_d    = (signed_i && dividend_i[31]) ? (32'd0 - dividend_i) : dividend_i;
      d_d    = (signed_i && divisor_i[31]) ? (32'd0 - divisor_i) : divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (!trial[32]) begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = rsh;
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    d_q  <= d_d;
    nq_q <= nq_d;
    nr_q <= nr_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd32) ? 1'b0 : (!busy_q && cnt_q == 6'd32);
  assign quot_o = nq_q ? (32'd0 - q_q) : q_q;
  assign rem_o  = nr_q ? (32'd0 - r_q) : r_q;

endmodule

// File: src/rie_back.sv
// Back end: register file, program counter and execution sequencer.
module rie_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    reset_pc_i,
  input  logic           dq_valid_i,
  output logic           dq_ready_o,
  input  rie_pkg::dec_t  dq_data_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output rie_pkg::res_t  res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    st_q, st_d;
  rie_pkg::dec_t ins_q;
  logic [31:0]   rf_q [32];
  logic [31:0]   a_q, rb_q, b_q;
  logic [31:0]   pc_q, pc_d;
  logic [31:0]   prod_q;
  logic          div_start, div_done;
  logic [31:0]   div_quot, div_rem;
  rie_pkg::res_t res_d, res_q;
  rie_pkg::res_t out_q;
  logic          rv_q;
  logic [31:0]   bval, link, boff, joff, val;
  logic          take;
  logic          slt_ab, slt_ba;
  logic          wr_rf;

  assign dq_ready_o  = (st_q == S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = out_q;

  // Instruction capture, register file read (r0 forced to zero) and write
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && dq_valid_i) begin
      ins_q <= dq_data_i;
    end
    if (st_q == S_READ) begin
      a_q  <= (ins_q.src_a == '0) ? '0 : rf_q[ins_q.src_a];
      rb_q <= (ins_q.src_b == '0) ? '0 : rf_q[ins_q.src_b];
    end
    if (wr_rf) begin
      rf_q[res_d.write_reg] <= res_d.write_value;
    end
    // keep the low word of the product
    if (st_q == S_EXEC) begin
      prod_q <= a_q * bval;
    end
  end

  // Operand B selection
  always_comb begin
    unique case (ins_q.bsrc)
      rie_pkg::BS_SEXT: bval = {{16{ins_q.imm16[15]}}, ins_q.imm16};
      rie_pkg::BS_ZEXT: bval = {16'd0, ins_q.imm16};
      default:          bval = rb_q;
    endcase
  end

  assign b_q    = bval;
  assign link   = pc_q + 32'd4;
  assign boff   = {{14{ins_q.imm16[15]}}, ins_q.imm16, 2'b00};
  assign joff   = {{4{ins_q.jump_offset[25]}}, ins_q.jump_offset, 2'b00};
  assign slt_ab = (a_q ^ 32'h8000_0000) < (rb_q ^ 32'h8000_0000);
  assign slt_ba = (rb_q ^ 32'h8000_0000) < (a_q ^ 32'h8000_0000);

  // Branch condition
  always_comb begin
    unique case (ins_q.op)
      rie_pkg::OP_BEQ:  take = (a_q == rb_q);
      rie_pkg::OP_BNE:  take = (a_q != rb_q);
      rie_pkg::OP_BLE:  take = !slt_ba;
      rie_pkg::OP_BLEU: take = (a_q <= rb_q);
      rie_pkg::OP_BLT:  take = slt_ab;
      rie_pkg::OP_BLTU: take = (a_q < rb_q);
      rie_pkg::OP_BGE:  take = !slt_ab;
      rie_pkg::OP_BGEU: take = (a_q >= rb_q);
      rie_pkg::OP_BGT:  take = slt_ba;
      rie_pkg::OP_BGTU: take = (a_q > rb_q);
      default:          take = 1'b0;
    endcase
  end

  // Combinational ALU result
  always_comb begin
    unique case (ins_q.op)
      rie_pkg::OP_ADD, rie_pkg::OP_ADDI: val = a_q + b_q;
      rie_pkg::OP_SUB, rie_pkg::OP_SUBI: val = a_q - b_q;
      rie_pkg::OP_AND, rie_pkg::OP_ANDI: val = a_q & b_q;
      rie_pkg::OP_OR, rie_pkg::OP_ORI:   val = a_q | b_q;
      rie_pkg::OP_XOR, rie_pkg::OP_XORI: val = a_q ^ b_q;
      rie_pkg::OP_XNOR, rie_pkg::OP_XNOR_IMM: val = ~(a_q ^ b_q);
      rie_pkg::OP_SLL, rie_pkg::OP_SLLI: val = a_q << b_q[4:0];
      rie_pkg::OP_SLR, rie_pkg::OP_SLRI: val = a_q >> b_q[4:0];
      rie_pkg::OP_SAR, rie_pkg::OP_SARI: val = 32'($signed(a_q) >>> b_q[4:0]);
      rie_pkg::OP_LDHI: val = {ins_q.imm16, 16'd0};
      default:          val = link;
    endcase
  end

  assign div_start = (st_q == S_EXEC) && (ins_q.cls == rie_pkg::CL_DIV) && (b_q != '0);

  rie_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .signed_i   (ins_q.div_signed),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Sequence one instruction
  always_comb begin
    st_d  = st_q;
    pc_d  = pc_q;
    res_d = res_q;
    wr_rf = 1'b0;
    unique case (st_q)
      S_IDLE: if (dq_valid_i) st_d = S_READ;
      S_READ: st_d = S_EXEC;
      S_EXEC: begin
        res_d                = '0;
        res_d.exception_code = rie_pkg::EXC_NONE;
        res_d.next_pc        = link;
        res_d.write_reg      = ins_q.dst;
        res_d.write_value    = val;
        res_d.write_enable   = ins_q.wr && (ins_q.dst != '0);
        st_d                 = S_DONE;
        unique case (ins_q.cls)
          rie_pkg::CL_MUL: st_d = S_MUL;
          rie_pkg::CL_DIV: begin
            if (b_q == '0) begin
              res_d                = '0;
              res_d.next_pc        = pc_q;
              res_d.exception_code = rie_pkg::EXC_DIVZERO;
            end else begin
              st_d = S_DIV;
            end
          end
          rie_pkg::CL_BRANCH: res_d.next_pc = take ? link + boff : link;
          rie_pkg::CL_JUMP: begin
            res_d.next_pc = (ins_q.op == rie_pkg::OP_JR || ins_q.op == rie_pkg::OP_JALR)
                            ? a_q : link + joff;
          end
          rie_pkg::CL_EXC: begin
            res_d                = '0;
            res_d.next_pc        = pc_q;
            res_d.exception_code = ins_q.exc;
          end
          default: ;
        endcase
        if (!res_d.write_enable) begin
          res_d.write_reg   = '0;
          res_d.write_value = '0;
        end
        if (st_d == S_DONE) begin
          wr_rf = res_d.write_enable;
          pc_d  = res_d.next_pc;
        end
      end
      S_MUL: begin
        res_d.write_value = res_q.write_enable ? prod_q : '0;
        wr_rf = res_q.write_enable;
        pc_d  = res_q.next_pc;
        st_d  = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          res_d.write_value = !res_q.write_enable ? '0 :
                              (ins_q.div_rem ? div_rem : div_quot);
          wr_rf = res_q.write_enable;
          pc_d  = res_q.next_pc;
          st_d  = S_DONE;
        end
      end
      S_DONE: if (!rv_q || res_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      pc_q <= reset_pc_i;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pc_q <= pc_d;
      if (st_q == S_DONE && (!rv_q || res_ready_i)) begin
        rv_q <= 1'b1;
      end else if (res_ready_i) begin
        rv_q <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (st_q != S_DONE) begin
      res_q <= res_d;
    end
  end

  // Load the output register once the previous result has left
  always_ff @(posedge clk_i) begin
    if (st_q == S_DONE && (!rv_q || res_ready_i)) begin
      out_q <= res_q;
    end
  end

endmodule

// File: src/risc32_integer_execute_unit.sv
// Top level of the 32-bit integer execute unit.
//
//  channel  | dir | handshake                         | payload
//  ---------+-----+-----------------------------------+--------------------------------
//  request  | in  | s_axis_tvalid / s_axis_tready     | s_axis_tdata (decoded instr.)
//  result   | out | m_axis_tvalid / m_axis_tready     | m_axis_tdata (pc, write, exc.)
//  config   | in  | cfg_we_i                          | cfg_wdata_i (reset_pc)
//
// Most instructions pass through queue, register read, execute and hand-off;
// multiplies add a product step; divides wait for the 32-step radix-2 divider.
// Reset empties the queue and sets the program counter to RESET_PC_DEFAULT.
// The front queue keeps accepting two requests while the back end stalls.
module risc32_integer_execute_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] op, [10:6] src_a, [15:11] src_b, [20:16] dest_r,
  // [36:21] imm16, [62:37] jump_offset, [63] zero
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] next_pc, [32] write_enable, [37:33] write_reg,
  // [69:38] write_value, [71:70] exception_code
  output logic [71:0]  m_axis_tdata
);

  logic [31:0]   reset_pc_q;
  logic          dq_valid, dq_ready;
  rie_pkg::dec_t dq_data;
  rie_pkg::res_t res;

  // Hold the reset vector register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_pc_q <= rie_pkg::RESET_PC_DEFAULT;
    end else if (cfg_we_i) begin
      reset_pc_q <= cfg_wdata_i;
    end
  end

  rie_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tdata[5:0]),
    .src_a_i       (s_axis_tdata[10:6]),
    .src_b_i       (s_axis_tdata[15:11]),
    .dest_r_i      (s_axis_tdata[20:16]),
    .imm16_i       (s_axis_tdata[36:21]),
    .jump_offset_i (s_axis_tdata[62:37]),
    .dq_valid_o    (dq_valid),
    .dq_ready_i    (dq_ready),
    .dq_data_o     (dq_data)
  );

  rie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reset_pc_i  (reset_pc_q),
    .dq_valid_i  (dq_valid),
    .dq_ready_o  (dq_ready),
    .dq_data_i   (dq_data),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.exception_code, res.write_value, res.write_reg,
                         res.write_enable, res.next_pc};

  // A result with an exception never writes a register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.exception_code != rie_pkg::EXC_NONE) |-> !res.write_enable)
    else $error("exception result carries a write");

  // r0 is never reported as written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.write_enable |-> (res.write_reg != '0))
    else $error("write to r0 reported");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

// File: tb/sv/rie_scoreboard.sv
// Result checker for the integer execute unit: watches both streams and predicts results.
`timescale 1ns / 1ps

module rie_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [71:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  logic [31:0]   gpr [32];
  logic [31:0]   pc_q;
  logic [31:0]   boot_pc;
  rie_pkg::res_t expected_q [$];

  // Execute one decoded instruction against the shadow state.
  function automatic rie_pkg::res_t execute_instr(input logic [63:0] d);
    logic [5:0]    op;
    logic [4:0]    rb_idx, rc_idx, dst;
    logic [31:0]   a, b, si, zi, boff, joff, nxt, val;
    logic          wr, immform;
    rie_pkg::exc_e exc;
    rie_pkg::res_t r;
    op      = d[5:0];
    a       = gpr[d[10:6]];
    b       = gpr[d[15:11]];
    rb_idx  = d[15:11];
    rc_idx  = d[20:16];
    zi      = {16'h0, d[36:21]};
    si      = {{16{d[36]}}, d[36:21]};
    boff    = si << 2;
    joff    = {{6{d[62]}}, d[62:37]} << 2;
    nxt     = pc_q + 32'd4;
    val     = '0;
    dst     = '0;
    wr      = 1'b0;
    immform = 1'b0;
    exc     = rie_pkg::EXC_NONE;
    case (op)
      rie_pkg::OP_ADD:  begin val = a + b; wr = 1'b1; end
      rie_pkg::OP_ADDI: begin val = a + si; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_SUB:  begin val = a - b; wr = 1'b1; end
      rie_pkg::OP_SUBI: begin val = a - si; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_MUL, rie_pkg::OP_MULU: begin val = a * b; wr = 1'b1; end
      rie_pkg::OP_MULI: begin val = a * si; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_MULU_IMM: begin val = a * zi; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_DIV, rie_pkg::OP_REM, rie_pkg::OP_DIVI, rie_pkg::OP_REMI: begin
        immform = (op == rie_pkg::OP_DIVI) || (op == rie_pkg::OP_REMI);
        if (immform) b = si;
        if ((immform && zi == 0) || (!immform && b == 0)) begin
          exc = rie_pkg::EXC_DIVZERO;
        end else begin
          wr = 1'b1;
          // most negative value over minus one wraps, remainder zero
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
            val = (op == rie_pkg::OP_DIV || op == rie_pkg::OP_DIVI) ? a : '0;
          else if (op == rie_pkg::OP_DIV || op == rie_pkg::OP_DIVI)
            val = $signed(a) / $signed(b);
          else
            val = $signed(a) % $signed(b);
        end
      end
      rie_pkg::OP_DIVU, rie_pkg::OP_REMU, rie_pkg::OP_DIVU_IMM,
      rie_pkg::OP_REMU_IMM: begin
        immform = (op == rie_pkg::OP_DIVU_IMM) || (op == rie_pkg::OP_REMU_IMM);
        if (immform) b = zi;
        if (b == 0) begin
          exc = rie_pkg::EXC_DIVZERO;
        end else begin
          wr  = 1'b1;
          val = (op == rie_pkg::OP_DIVU || op == rie_pkg::OP_DIVU_IMM) ? a / b : a % b;
        end
      end
      rie_pkg::OP_AND:  begin val = a & b; wr = 1'b1; end
      rie_pkg::OP_ANDI: begin val = a & zi; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_OR:   begin val = a | b; wr = 1'b1; end
      rie_pkg::OP_ORI:  begin val = a | zi; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_XOR:  begin val = a ^ b; wr = 1'b1; end
      rie_pkg::OP_XORI: begin val = a ^ zi; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_XNOR: begin val = ~(a ^ b); wr = 1'b1; end
      rie_pkg::OP_XNOR_IMM: begin val = ~(a ^ zi); wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_SLL:  begin val = a << b[4:0]; wr = 1'b1; end
      rie_pkg::OP_SLLI: begin val = a << zi[4:0]; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_SLR:  begin val = a >> b[4:0]; wr = 1'b1; end
      rie_pkg::OP_SLRI: begin val = a >> zi[4:0]; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_SAR:  begin val = $signed(a) >>> b[4:0]; wr = 1'b1; end
      rie_pkg::OP_SARI: begin val = $signed(a) >>> zi[4:0]; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_LDHI: begin val = zi << 16; wr = 1'b1; immform = 1'b1; end
      rie_pkg::OP_BEQ:  if (a == b) nxt = nxt + boff;
      rie_pkg::OP_BNE:  if (a != b) nxt = nxt + boff;
      rie_pkg::OP_BLE:  if ($signed(a) <= $signed(b)) nxt = nxt + boff;
      rie_pkg::OP_BLEU: if (a <= b) nxt = nxt + boff;
      rie_pkg::OP_BLT:  if ($signed(a) < $signed(b)) nxt = nxt + boff;
      rie_pkg::OP_BLTU: if (a < b) nxt = nxt + boff;
      rie_pkg::OP_BGE:  if ($signed(a) >= $signed(b)) nxt = nxt + boff;
      rie_pkg::OP_BGEU: if (a >= b) nxt = nxt + boff;
      rie_pkg::OP_BGT:  if ($signed(a) > $signed(b)) nxt = nxt + boff;
      rie_pkg::OP_BGTU: if (a > b) nxt = nxt + boff;
      rie_pkg::OP_J:    nxt = nxt + joff;
      rie_pkg::OP_JR:   nxt = a;
      rie_pkg::OP_JAL: begin
        val = nxt; dst = rie_pkg::LINK_REG; wr = 1'b1; nxt = nxt + joff;
      end
      rie_pkg::OP_JALR: begin
        val = nxt; dst = rie_pkg::LINK_REG; wr = 1'b1; nxt = a;
      end
      rie_pkg::OP_TRAP: exc = rie_pkg::EXC_USER_TRAP;
      default:          exc = rie_pkg::EXC_ILLEGAL;
    endcase
    // commit: exceptions hold the pc and drop the write, r0 stays zero
    if (exc != rie_pkg::EXC_NONE) begin
      wr  = 1'b0;
      nxt = pc_q;
    end else if (wr) begin
      if (op != rie_pkg::OP_JAL && op != rie_pkg::OP_JALR) dst = immform ? rb_idx : rc_idx;
      if (dst == 0) wr = 1'b0;
      else gpr[dst] = val;
    end
    pc_q = nxt;
    r.next_pc        = nxt;
    r.write_enable   = wr;
    r.write_reg      = wr ? dst : '0;
    r.write_value    = wr ? val : '0;
    r.exception_code = exc;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rie_pkg::res_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      boot_pc      = rie_pkg::RESET_PC_DEFAULT;
      pc_q         = boot_pc;
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // has no effect on the pc: reset restores the default boot_pc
      if (cfg_we_i) boot_pc = cfg_wdata_i;
      // check the outgoing result against the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got.next_pc        = m_tdata_i[31:0];
        got.write_enable   = m_tdata_i[32];
        got.write_reg      = m_tdata_i[37:33];
        got.write_value    = m_tdata_i[69:38];
        got.exception_code = rie_pkg::exc_e'(m_tdata_i[71:70]);
        checked_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with nothing outstanding: %h", $realtime, m_tdata_i);
        end else begin
          want = expected_q.pop_front();
          if (got.next_pc !== want.next_pc || got.write_enable !== want.write_enable ||
              got.write_reg !== want.write_reg || got.write_value !== want.write_value ||
              got.exception_code !== want.exception_code) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch pc %h/%h we %b/%b reg %0d/%0d val %h/%h exc %0d/%0d",
                       $realtime, want.next_pc, got.next_pc, want.write_enable,
                       got.write_enable, want.write_reg, got.write_reg, want.write_value,
                       got.write_value, want.exception_code, got.exception_code);
          end
        end
      end
      // predict on every accepted request
      if (s_tvalid_i && s_tready_i) expected_q.push_back(execute_instr(s_tdata_i));
    end
    pending_o = expected_q.size();
  end

endmodule

// File: tb/sv/tb_risc32_integer_execute_unit.sv
// Stimulus and verdict for the integer execute unit testbench.
`timescale 1ns / 1ps

module tb_risc32_integer_execute_unit;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  int          fail_count, pending, checked;
  int          sent;
  logic [31:0] known_regs;
  logic        no_gaps;

  risc32_integer_execute_unit DUT (.*);

  rie_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Hold off the result side at random, with stretches of steady ready.
  initial begin
    int steady;
    steady = 0;
    forever begin
      @(negedge clk_i);
      if (steady > 0) begin
        steady--;
        m_axis_tready = 1;
      end else if ($urandom_range(19) == 0) begin
        steady = $urandom_range(80, 20);
        m_axis_tready = 1;
      end else begin
        m_axis_tready = 0;
        repeat (gap_len()) @(negedge clk_i);
        m_axis_tready = 1;
      end
    end
  end

  function automatic logic [63:0] pack_instr(logic [5:0] op, logic [4:0] ra, logic [4:0] rb,
                                             logic [4:0] rc, logic [15:0] imm,
                                             logic [25:0] joff);
    return {1'b0, joff, imm, rc, rb, ra, op};
  endfunction

  function automatic logic [4:0] pick_known();
    logic [4:0] r;
    do r = 5'($urandom_range(31)); while (!known_regs[r]);
    return r;
  endfunction

  // Mark destinations that surely got written (divides are left out).
  function automatic void note_write(logic [63:0] d);
    logic [5:0] op;
    op = d[5:0];
    if (op == rie_pkg::OP_JAL || op == rie_pkg::OP_JALR) known_regs[rie_pkg::LINK_REG] = 1;
    else if (op <= rie_pkg::OP_SARI &&
             !(op >= rie_pkg::OP_DIV && op <= rie_pkg::OP_REMU_IMM))
      known_regs[op[0] ? d[15:11] : d[20:16]] = 1;
    else if (op == rie_pkg::OP_LDHI) known_regs[d[15:11]] = 1;
  endfunction

  // Present one request and hold it until it is taken.
  task automatic send_instr(logic [63:0] d);
    int g;
    g = no_gaps ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid = 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata  = d;
    s_axis_tvalid = 1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    note_write(d);
    sent++;
  endtask

  // Drain all results, let the block settle, then load reset_pc.
  task automatic drain_and_config(logic [31:0] value);
    s_axis_tvalid = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  function automatic logic [63:0] random_instr();
    logic [5:0]  op;
    logic [4:0]  ra, rb;
    logic [15:0] imm;
    op = ($urandom_range(99) < 6) ? 6'($urandom_range(63, 46)) : 6'($urandom_range(45));
    case ($urandom_range(9))
      0:       imm = 16'h0000;
      1:       imm = 16'hFFFF;
      2:       imm = 16'h8000;
      3:       imm = 16'h7FFF;
      default: imm = 16'($urandom);
    endcase
    ra = pick_known();
    // register forms and branches read src_b; immediate forms write it
    if ((op <= rie_pkg::OP_SAR && !op[0]) ||
        (op >= rie_pkg::OP_BEQ && op <= rie_pkg::OP_BGTU)) rb = pick_known();
    else rb = 5'($urandom_range(31));
    return pack_instr(op, ra, rb, 5'($urandom_range(31)), imm, 26'($urandom));
  endfunction

  initial begin
    int phase;
    sent       = 0;
    known_regs = 32'h1;
    no_gaps    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    drain_and_config(32'h0000_0000);

    // directed: operand extremes and the corner cases
    send_instr(pack_instr(rie_pkg::OP_LDHI, 0, 1, 0, 16'h8000, 0));   // r1 = most negative
    send_instr(pack_instr(rie_pkg::OP_ORI, 0, 2, 0, 16'hFFFF, 0));    // r2 = 0xFFFF
    send_instr(pack_instr(rie_pkg::OP_LDHI, 0, 3, 0, 16'hFFFF, 0));
    send_instr(pack_instr(rie_pkg::OP_ORI, 3, 3, 0, 16'hFFFF, 0));    // r3 = -1
    send_instr(pack_instr(rie_pkg::OP_ADDI, 0, 4, 0, 16'h0000, 0));   // r4 = 0
    send_instr(pack_instr(rie_pkg::OP_DIV, 1, 3, 5, 0, 0));           // signed overflow
    send_instr(pack_instr(rie_pkg::OP_REM, 1, 3, 6, 0, 0));
    send_instr(pack_instr(rie_pkg::OP_DIVI, 1, 12, 0, 16'hFFFF, 0));
    send_instr(pack_instr(rie_pkg::OP_REMI, 1, 11, 0, 16'hFFFF, 0));
    send_instr(pack_instr(rie_pkg::OP_DIV, 1, 4, 7, 0, 0));           // zero divisor
    send_instr(pack_instr(rie_pkg::OP_REMU, 3, 4, 7, 0, 0));
    send_instr(pack_instr(rie_pkg::OP_DIVU_IMM, 3, 7, 0, 16'h0000, 0));
    send_instr(pack_instr(rie_pkg::OP_ADD, 3, 3, 0, 0, 0));           // write to r0
    send_instr(pack_instr(rie_pkg::OP_SLL, 3, 2, 8, 0, 0));           // count from low bits
    send_instr(pack_instr(rie_pkg::OP_SARI, 1, 9, 0, 16'hFFFF, 0));
    send_instr(pack_instr(rie_pkg::OP_MULU, 3, 3, 10, 0, 0));
    send_instr(pack_instr(rie_pkg::OP_SUBI, 1, 13, 0, 16'h0001, 0));  // wraps
    send_instr(pack_instr(rie_pkg::OP_JAL, 0, 0, 0, 0, 26'h3FF_FFFF));
    send_instr(pack_instr(rie_pkg::OP_JALR, 31, 0, 0, 0, 0));         // target is old r31
    send_instr(pack_instr(rie_pkg::OP_BEQ, 0, 0, 0, 16'h8000, 0));
    send_instr(pack_instr(rie_pkg::OP_BGTU, 3, 0, 0, 16'h7FFF, 0));
    send_instr(pack_instr(rie_pkg::OP_J, 0, 0, 0, 0, 26'h200_0000));
    send_instr(pack_instr(rie_pkg::OP_TRAP, 0, 0, 0, 0, 0));
    send_instr(pack_instr(6'd46, 0, 0, 0, 0, 0));                     // illegal
    send_instr(pack_instr(6'd63, 31, 31, 31, 16'hFFFF, 26'h3FF_FFFF));
    drain_and_config(32'hFFFF_FFFF);

    // random phases, one of them without idle gaps on the request side
    for (phase = 0; phase < 4; phase++) begin
      no_gaps = (phase == 2);
      repeat (250) send_instr(random_instr());
      drain_and_config(phase == 3 ? rie_pkg::RESET_PC_DEFAULT : $urandom);
    end

    $display("sent %0d requests (directed corner cases, then random programs)", sent);
    $display("checked %0d results, reset_pc rewritten while idle between phases", checked);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
